FILE: hdl/blru_pkg.sv
// Shared constants, codes and types of the byte budget LRU image cache.
package blru_pkg;

    // Table geometry
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = 5;
    localparam int DIM_W   = 14;
    localparam int BYTE_W  = 40;
    localparam int STAMP_W = 48;
    localparam int CODE_W  = 3;
    localparam int CIDX_W  = 2;
    localparam int PROD_W  = 2 * DIM_W;
    localparam int NEED_W  = PROD_W + 2;

    localparam logic [BYTE_W-1:0] BYTE_LIMIT_RST = 40'd268435456;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_BYTE_LIMIT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_HEIGHT = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_REQUEST = 2'd0,
        KIND_FINISH  = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [CODE_W-1:0] {
        RES_HIT     = 3'd0,
        RES_START   = 3'd1,
        RES_MISS    = 3'd2,
        RES_EVICT   = 3'd3,
        RES_LOADED  = 3'd4,
        RES_FAILED  = 3'd5,
        RES_IGNORED = 3'd6,
        RES_CLEARED = 3'd7
    } res_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_EVAL,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_END,
        ST_EVICT_MUL,
        ST_EVICT,
        ST_FINAL
    } state_t;

    // One table row
    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               resident;
        logic               bad;
        logic [STAMP_W-1:0] stamp;
    } row_t;

    // Access to the entry table
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        row_t             wr_row;
        logic             clear;
    } tbl_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_limit;
        logic [DIM_W-1:0]  max_width;
        logic [DIM_W-1:0]  max_height;
    } cfg_t;

    // One result word from the sequencer
    typedef struct packed {
        logic               valid;
        res_code_t          code;
        logic [ENTRY_W-1:0] entry;
        logic               bad;
        logic [BYTE_W-1:0]  bytes;
        logic               last;
    } emit_t;

endpackage

FILE: hdl/blru_table.sv
// Entry table: synchronous row memory with per-entry known bits and clear.
module blru_table import blru_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tbl_req_t req,
    output row_t     rd_row,
    output logic     rd_known
);

    row_t               mem [ENTRIES];
    logic [ENTRIES-1:0] known_reg;
    row_t               rd_data_reg;
    logic               rd_known_reg;
    logic               fwd;

    // Forward a write that lands on the address being read
    assign fwd = req.wr_en && (req.wr_addr == req.rd_addr);

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_row;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= fwd ? req.wr_row : mem[req.rd_addr];
        end
    end

    // Known bits: clear empties the whole table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg    <= '0;
            rd_known_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                known_reg <= '0;
            end
            else if (req.wr_en)
            begin
                known_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_known_reg <= fwd | known_reg[req.rd_addr];
            end
        end
    end

    // An entry never written since the last clear reads as zero
    assign rd_row   = rd_known_reg ? rd_data_reg : '0;
    assign rd_known = rd_known_reg;

endmodule

FILE: hdl/blru_ctrl.sv
// Sequencer: request check, load completion, LRU eviction scan and clear.
module blru_ctrl import blru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [DIM_W-1:0]   width,
    input  logic [DIM_W-1:0]   height,
    input  logic               decode_ok,
    input  logic               upload_ok,
    input  cfg_t               cfg,
    input  logic               emit_ok,
    output logic               busy,
    output emit_t              emit,
    output tbl_req_t           tbl,
    input  row_t               rd_row,
    input  logic               rd_known
);

    state_t             state_reg, state_next;

    // Item registers
    kind_t              kind_reg;
    logic [ENTRY_W-1:0] entry_reg;
    logic [DIM_W-1:0]   w_reg, h_reg;
    logic               dok_reg, uok_reg;
    row_t               row_reg;
    logic               known_cur_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Cache-wide state
    logic [BYTE_W-1:0]  bytes_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic               pend_busy_reg;
    logic [ENTRY_W-1:0] pend_entry_reg;
    logic               stale_reg;

    // Eviction scan
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic               scan_vld_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    row_t               best_row_reg;
    logic [PROD_W-1:0]  ev_prod_reg;

    logic               accept;
    kind_t              in_kind;
    logic [IDX_W-1:0]   cur_idx, pend_idx;
    logic               idx_ok, pend_ok;
    logic [NEED_W-1:0]  need, ev_need;
    logic               over;
    logic               new_bad;
    logic [STAMP_W-1:0] stamp_next;
    row_t               req_row;
    logic               load_go;
    logic               scan_take;
    logic               scan_done;

    assign accept    = (state_reg == ST_IDLE) && req_valid;
    assign busy      = (state_reg != ST_IDLE);
    assign in_kind   = kind_t'(kind);
    assign cur_idx   = IDX_W'(entry_reg);
    assign pend_idx  = IDX_W'(pend_entry_reg);
    assign idx_ok    = int'(entry_reg) < ENTRIES;
    assign pend_ok   = int'(pend_entry_reg) < ENTRIES;
    assign need      = {prod_reg, 2'b00};
    assign ev_need   = {ev_prod_reg, 2'b00};
    assign stamp_next = clock_reg + STAMP_W'(1);
    assign scan_done = (scan_cnt_reg == CNT_W'(ENTRIES - 1));

    // Budget overflow with the image to load
    assign over = ({1'b0, bytes_reg} + (BYTE_W + 1)'(need)) > {1'b0, cfg.byte_limit};

    // Failure check of a first request
    assign new_bad = (w_reg == '0) || (h_reg == '0)
                  || (BYTE_W'(need) > cfg.byte_limit)
                  || ((cfg.max_width != '0) && (w_reg > cfg.max_width))
                  || ((cfg.max_height != '0) && (h_reg > cfg.max_height));

    // Row after a request: fill on first use, refresh stamp on a hit
    always_comb
    begin
        if (known_cur_reg)
        begin
            req_row = row_reg;
        end
        else
        begin
            req_row          = '0;
            req_row.width    = w_reg;
            req_row.height   = h_reg;
            req_row.bad      = new_bad;
        end
        if (req_row.resident)
        begin
            req_row.stamp = stamp_next;
        end
    end

    // A finished load that goes on to the eviction loop
    assign load_go = (kind_reg == KIND_FINISH) && pend_busy_reg && !stale_reg
                  && pend_ok && known_cur_reg && dok_reg;

    // Older resident found in the scan
    assign scan_take = scan_vld_reg && rd_row.resident
                    && (!best_found_reg || (rd_row.stamp < best_row_reg.stamp));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (load_go)
                begin
                    state_next = ST_CHECK;
                end
                else if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = over ? ST_SCAN : ST_FINAL;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_EVICT_MUL;
            end
            ST_EVICT_MUL:
            begin
                state_next = best_found_reg ? ST_EVICT : ST_FINAL;
            end
            ST_EVICT:
            begin
                if (emit_ok)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINAL:
            begin
                if (emit_ok)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Table accesses and result words
    always_comb
    begin
        tbl          = '0;
        emit         = '0;
        emit.code    = RES_IGNORED;
        emit.bytes   = bytes_reg;
        emit.last    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                tbl.rd_en   = accept;
                tbl.rd_addr = (in_kind == KIND_FINISH) ? pend_idx : IDX_W'(entry);
            end
            ST_EVAL:
            begin
                emit.valid = emit_ok && !load_go;
                case (kind_reg)
                    KIND_REQUEST:
                    begin
                        emit.entry = entry_reg;
                        if (idx_ok)
                        begin
                            tbl.wr_en   = emit_ok;
                            tbl.wr_addr = cur_idx;
                            tbl.wr_row  = req_row;
                            emit.bad    = req_row.bad;
                            if (req_row.resident)
                            begin
                                emit.code = RES_HIT;
                            end
                            else if (!req_row.bad && !pend_busy_reg)
                            begin
                                emit.code = RES_START;
                            end
                            else
                            begin
                                emit.code = RES_MISS;
                            end
                        end
                        else
                        begin
                            emit.code = RES_MISS;
                        end
                    end
                    KIND_FINISH:
                    begin
                        if (pend_busy_reg)
                        begin
                            emit.entry = pend_entry_reg;
                            if (!stale_reg && pend_ok && known_cur_reg && !dok_reg)
                            begin
                                tbl.wr_en      = emit_ok;
                                tbl.wr_addr    = pend_idx;
                                tbl.wr_row     = row_reg;
                                tbl.wr_row.bad = 1'b1;
                                emit.code      = RES_FAILED;
                                emit.bad       = 1'b1;
                            end
                        end
                    end
                    KIND_CLEAR:
                    begin
                        tbl.clear  = emit_ok;
                        emit.code  = RES_CLEARED;
                        emit.bytes = '0;
                    end
                    KIND_NONE:
                    begin
                        emit.code = RES_IGNORED;
                    end
                    default:
                    begin
                        emit.code = RES_IGNORED;
                    end
                endcase
            end
            ST_SCAN:
            begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = scan_cnt_reg[IDX_W-1:0];
            end
            ST_EVICT:
            begin
                tbl.wr_en           = emit_ok;
                tbl.wr_addr         = best_idx_reg;
                tbl.wr_row          = best_row_reg;
                tbl.wr_row.resident = 1'b0;
                emit.valid          = emit_ok;
                emit.code           = RES_EVICT;
                emit.entry          = ENTRY_W'(best_idx_reg);
                emit.bad            = row_reg.bad;
                emit.bytes          = bytes_reg - BYTE_W'(ev_need);
                emit.last           = 1'b0;
            end
            ST_FINAL:
            begin
                tbl.wr_en   = emit_ok;
                tbl.wr_addr = pend_idx;
                tbl.wr_row  = row_reg;
                emit.valid  = emit_ok;
                emit.entry  = pend_entry_reg;
                if (uok_reg)
                begin
                    tbl.wr_row.resident = 1'b1;
                    tbl.wr_row.stamp    = stamp_next;
                    emit.code           = RES_LOADED;
                    emit.bad            = row_reg.bad;
                    emit.bytes          = bytes_reg + BYTE_W'(need);
                end
                else
                begin
                    tbl.wr_row.bad = 1'b1;
                    emit.code      = RES_FAILED;
                    emit.bad       = 1'b1;
                end
            end
            default:
            begin
                tbl.rd_en = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bytes_reg      <= '0;
            clock_reg      <= '0;
            pend_busy_reg  <= 1'b0;
            pend_entry_reg <= '0;
            stale_reg      <= 1'b0;
            scan_cnt_reg   <= '0;
            scan_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_vld_reg <= (state_reg == ST_SCAN);
            if (scan_take)
            begin
                best_found_reg <= 1'b1;
            end
            unique case (state_reg)
                ST_EVAL:
                begin
                    if (emit_ok || load_go)
                    begin
                        case (kind_reg)
                            KIND_REQUEST:
                            begin
                                if (idx_ok && req_row.resident)
                                begin
                                    clock_reg <= stamp_next;
                                end
                                else if (idx_ok && !req_row.bad && !pend_busy_reg)
                                begin
                                    pend_busy_reg  <= 1'b1;
                                    pend_entry_reg <= entry_reg;
                                    stale_reg      <= 1'b0;
                                end
                            end
                            KIND_FINISH:
                            begin
                                pend_busy_reg <= 1'b0;
                            end
                            KIND_CLEAR:
                            begin
                                bytes_reg <= '0;
                                stale_reg <= stale_reg | pend_busy_reg;
                            end
                            default:
                            begin
                                bytes_reg <= bytes_reg;
                            end
                        endcase
                    end
                end
                ST_CHECK:
                begin
                    scan_cnt_reg   <= '0;
                    best_found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                ST_EVICT:
                begin
                    if (emit_ok)
                    begin
                        bytes_reg <= bytes_reg - BYTE_W'(ev_need);
                    end
                end
                ST_FINAL:
                begin
                    if (emit_ok && uok_reg)
                    begin
                        bytes_reg <= bytes_reg + BYTE_W'(need);
                        clock_reg <= stamp_next;
                    end
                end
                default:
                begin
                    scan_cnt_reg <= scan_cnt_reg;
                end
            endcase
        end
    end

    // Item payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in_kind;
            entry_reg <= entry;
            w_reg     <= width;
            h_reg     <= height;
            dok_reg   <= decode_ok;
            uok_reg   <= upload_ok;
        end
        if (state_reg == ST_PROD)
        begin
            row_reg       <= rd_row;
            known_cur_reg <= rd_known;
            if (kind_reg == KIND_FINISH)
            begin
                prod_reg <= PROD_W'(rd_row.width) * PROD_W'(rd_row.height);
            end
            else
            begin
                prod_reg <= PROD_W'(w_reg) * PROD_W'(h_reg);
            end
        end
        scan_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        if (scan_take)
        begin
            best_idx_reg <= scan_idx_reg;
            best_row_reg <= rd_row;
        end
        if (state_reg == ST_EVICT_MUL)
        begin
            ev_prod_reg <= PROD_W'(best_row_reg.width) * PROD_W'(best_row_reg.height);
        end
    end

endmodule

FILE: hdl/byte_budget_lru_cache.sv
// Top level of the byte budget LRU image cache.
//
// Input channel (req_valid / req_stall) takes one command word: a request
// for an entry, a finished load, or a clear. Output channel (res_valid /
// res_stall) gives one or more result words per command, the final one
// flagged by last. The user writes configuration (byte_limit, max_width,
// max_height) through cfg_we / cfg_index / cfg_data only while the cache
// is idle; the block itself does not enforce this.
//
// A request, a clear, an ignored command or a failed decode goes from
// ST_PROD to ST_EVAL, where its result word enters the output register.
// A load that goes on to the budget check enters ST_CHECK; each eviction
// is one pass over the entry table through its single read port, then
// ST_SCAN_END, ST_EVICT_MUL and ST_EVICT, and back to ST_CHECK. If the
// image still does not fit once no resident is left, a last scan finds
// nothing. One command is in work at a time; req_stall is high until its
// last result word has been loaded into the output register.
//
// Reset clears the table, the byte total, the use clock and the load slot,
// and loads the default configuration. A stalled output holds its word and
// the sequencer waits for the register to free up.
module byte_budget_lru_cache import blru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [ENTRY_W-1:0] entry,
    input  logic [DIM_W-1:0]   width,
    input  logic [DIM_W-1:0]   height,
    input  logic               decode_ok,
    input  logic               upload_ok,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [CODE_W-1:0]  result_code,
    output logic [ENTRY_W-1:0] result_entry,
    output logic               entry_failed,
    output logic [BYTE_W-1:0]  bytes_in_use,
    output logic               last,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]  cfg_data
);

    cfg_t               cfg_reg;
    logic               res_valid_reg;
    res_code_t          code_reg;
    logic [ENTRY_W-1:0] entry_out_reg;
    logic               bad_reg;
    logic [BYTE_W-1:0]  bytes_out_reg;
    logic               last_reg;

    logic               emit_ok;
    logic               busy;
    emit_t              emit;
    tbl_req_t           tbl;
    row_t               rd_row;
    logic               rd_known;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_limit <= BYTE_LIMIT_RST;
            cfg_reg.max_width  <= '0;
            cfg_reg.max_height <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BYTE_LIMIT: cfg_reg.byte_limit <= cfg_data;
                REG_MAX_WIDTH:  cfg_reg.max_width  <= cfg_data[DIM_W-1:0];
                REG_MAX_HEIGHT: cfg_reg.max_height <= cfg_data[DIM_W-1:0];
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    blru_table u_table
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl),
        .rd_row   (rd_row),
        .rd_known (rd_known)
    );

    blru_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .kind      (kind),
        .entry     (entry),
        .width     (width),
        .height    (height),
        .decode_ok (decode_ok),
        .upload_ok (upload_ok),
        .cfg       (cfg_reg),
        .emit_ok   (emit_ok),
        .busy      (busy),
        .emit      (emit),
        .tbl       (tbl),
        .rd_row    (rd_row),
        .rd_known  (rd_known)
    );

    assign req_stall = busy;

    // Output register is free when empty or being taken
    assign emit_ok = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            code_reg      <= emit.code;
            entry_out_reg <= emit.entry;
            bad_reg       <= emit.bad;
            bytes_out_reg <= emit.bytes;
            last_reg      <= emit.last;
        end
    end

    assign res_valid    = res_valid_reg;
    assign result_code  = code_reg;
    assign result_entry = entry_out_reg;
    assign entry_failed = bad_reg;
    assign bytes_in_use = bytes_out_reg;
    assign last         = last_reg;

endmodule
